>>> hdl/grdc_pkg.sv
package grdc_pkg;

	localparam int MAP_SIZE_DEF    = 64;
	localparam int MAX_COLUMNS_DEF = 2048;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH = 3'd0,
		REG_CAM_POS_X    = 3'd1,
		REG_CAM_POS_Y    = 3'd2,
		REG_VIEW_DIR_X   = 3'd3,
		REG_VIEW_DIR_Y   = 3'd4,
		REG_CAM_PLANE_X  = 3'd5,
		REG_CAM_PLANE_Y  = 3'd6
	} reg_idx_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic clr_step;    // clearing pass: write zero at clear address
		logic map_write;   // write item into the map
		logic load;        // capture the cast column (clamped to MAX_COLUMNS - 1)
		logic div_step;    // one bit of a shared restoring division
		logic div_start;   // load divider with selected operands
		logic div_sel;     // 0: cam_x, 1: ray x/y recip
		logic mul_step;    // cam_x / plane product / ray stages
		logic side_init;   // form first side distances
		logic walk_step;   // one DDA step, issue map read
		logic hit_latch;   // latch result
	} grdc_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic start_out;  // camera cell outside the map
		logic walk_out;   // walk left the map on last step
		logic hit;        // read cell nonzero
	} grdc_sts_t;

endpackage

>>> hdl/grdc_ram.sv
module grdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/grdc_datapath.sv
module grdc_datapath import grdc_pkg::*; #(
	parameter int MAP_SIZE    = MAP_SIZE_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  grdc_cmd_t          cmd,
	input  logic [1:0]         div_phase,  // 0 cam_x, 1 recip x, 2 recip y
	output grdc_sts_t          sts,
	input  logic [11:0]        screen_width,
	input  logic [15:0]        cam_pos_x,
	input  logic [15:0]        cam_pos_y,
	input  logic signed [15:0] view_dir_x,
	input  logic signed [15:0] view_dir_y,
	input  logic signed [15:0] cam_plane_x,
	input  logic signed [15:0] cam_plane_y,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_y,
	input  logic [7:0]         cell_code,
	input  logic [10:0]        column,
	output logic [5:0]         hit_x,
	output logic [5:0]         hit_y,
	output logic               hit_side,
	output logic [7:0]         wall_code
);
	localparam int MW = $clog2(MAP_SIZE);
	localparam int AW = 2 * MW;
	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int XW = CW + 16;  // cam_x width, quotient below 2^(CW+15)
	localparam int PW = XW + 16;  // plane * cam_x width
	localparam int DW = 40;   // dividend width
	localparam int RW = 36;   // ray magnitude width

	// clearing pass
	logic [AW:0] clr_q;
	assign sts.clr_done = clr_q[AW];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
	end

	// walk state
	logic signed [MW+1:0] mx_q, my_q;
	logic [31:0] sdx_q, sdy_q, ddx_q, ddy_q;
	logic negx_q, negy_q, side_q;

	// map
	logic           ram_we;
	logic [AW-1:0]  ram_wa, ram_ra;
	logic [7:0]     ram_wd, ram_rd;
	logic signed [MW+1:0] nmx, nmy;
	logic           stepx;

	assign stepx = sdx_q < sdy_q;
	always_comb begin
		nmx = mx_q;
		nmy = my_q;
		if (stepx) nmx = negx_q ? mx_q - 1'b1 : mx_q + 1'b1;
		else       nmy = negy_q ? my_q - 1'b1 : my_q + 1'b1;
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = {MW'(cell_x), MW'(cell_y)};
		ram_wd = cell_code;
		if (cmd.clr_step) begin
			ram_we = 1'b1;
			ram_wa = clr_q[AW-1:0];
			ram_wd = '0;
		end else if (cmd.map_write) begin
			ram_we = (32'(cell_x) < MAP_SIZE) && (32'(cell_y) < MAP_SIZE);
		end
	end
	assign ram_ra = {nmx[MW-1:0], nmy[MW-1:0]};

	grdc_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_map (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic walk_out_q;
	assign sts.walk_out = walk_out_q;
	assign sts.hit = ram_rd != 8'd0;
	assign sts.start_out = (32'(cam_pos_x[15:10]) >= MAP_SIZE) ||
		(32'(cam_pos_y[15:10]) >= MAP_SIZE);

	// shared restoring divider, one quotient bit per cycle
	logic [DW-1:0] dq_q;     // dividend shifting into quotient
	logic [RW:0]   rem_q;
	logic [RW-1:0] dvs_q;
	logic [5:0]    dcnt_q;
	logic [RW:0]   rtry;
	assign rtry = {rem_q[RW-1:0], dq_q[DW-1]} - {1'b0, dvs_q};
	assign sts.div_done = dcnt_q == 6'd0;

	logic [CW-1:0] col_q;
	logic signed [RW:0] rayx_q, rayy_q;
	logic [RW-1:0] magx, magy;
	logic signed [XW-1:0] camx_q;
	assign magx = rayx_q[RW] ? RW'(-rayx_q) : RW'(rayx_q);
	assign magy = rayy_q[RW] ? RW'(-rayy_q) : RW'(rayy_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= (32'(column) > MAX_COLUMNS - 1) ? CW'(MAX_COLUMNS - 1)
				: CW'(column);
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			dcnt_q <= 6'(DW);
			if (!cmd.div_sel) begin
				dq_q <= DW'({col_q, 15'd0});
				dvs_q <= (screen_width == 12'd0) ? RW'(1) : RW'(screen_width);
			end else begin
				dq_q <= DW'(64'd1 << 30);
				dvs_q <= (div_phase == 2'd1) ? magx : magy;
			end
		end else if (cmd.div_step && dcnt_q != 6'd0) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (!rtry[RW]) begin
				rem_q <= rtry;
				dq_q <= {dq_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[RW-1:0], dq_q[DW-1]};
				dq_q <= {dq_q[DW-2:0], 1'b0};
			end
		end
	end

	// cam_x, ray products (plane * cam_x, floor >> 14), reciprocal latch, side products
	logic signed [PW-1:0] px_s1, py_s1;
	logic [42:0] fx_s1, fy_s1;
	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			if (div_phase == 2'd0) begin
				camx_q <= XW'(dq_q[XW-2:0]) - XW'(16384);
			end else if (div_phase == 2'd1) begin
				px_s1 <= cam_plane_x * camx_q;
				py_s1 <= cam_plane_y * camx_q;
			end else begin
				rayx_q <= (RW+1)'(view_dir_x) + (RW+1)'(px_s1 >>> 14);
				rayy_q <= (RW+1)'(view_dir_y) + (RW+1)'(py_s1 >>> 14);
			end
		end
		if (cmd.div_sel && sts.div_done && !cmd.div_start && !cmd.mul_step) begin
			if (div_phase == 2'd1)
				ddx_q <= (magx == '0 || dq_q[DW-1:32] != '0) ? 32'hFFFFFFFF
					: dq_q[31:0];
			else if (div_phase == 2'd2)
				ddy_q <= (magy == '0 || dq_q[DW-1:32] != '0) ? 32'hFFFFFFFF
					: dq_q[31:0];
		end
		if (cmd.side_init) begin
			fx_s1 <= (rayx_q[RW] ? 43'(cam_pos_x[9:0]) : 43'(11'd1024 - cam_pos_x[9:0]))
				* 43'(ddx_q);
			fy_s1 <= (rayy_q[RW] ? 43'(cam_pos_y[9:0]) : 43'(11'd1024 - cam_pos_y[9:0]))
				* 43'(ddy_q);
			negx_q <= rayx_q[RW];
			negy_q <= rayy_q[RW];
		end
	end

	// walk
	logic [32:0] sumx, sumy;
	assign sumx = {1'b0, sdx_q} + {1'b0, ddx_q};
	assign sumy = {1'b0, sdy_q} + {1'b0, ddy_q};
	logic init_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_d_q <= 1'b0;
			walk_out_q <= 1'b0;
			side_q <= 1'b0;
		end else begin
			init_d_q <= cmd.side_init;
			if (cmd.side_init) side_q <= 1'b0;
			if (cmd.walk_step) begin
				side_q <= !stepx;
				walk_out_q <= nmx < 0 || nmy < 0 || nmx >= MAP_SIZE
					|| nmy >= MAP_SIZE;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (init_d_q) begin
			sdx_q <= fx_s1[41:10];
			sdy_q <= fy_s1[41:10];
			mx_q <= (MW+2)'(cam_pos_x[15:10]);
			my_q <= (MW+2)'(cam_pos_y[15:10]);
		end else if (cmd.walk_step) begin
			if (stepx) sdx_q <= sumx[32] ? 32'hFFFFFFFF : sumx[31:0];
			else       sdy_q <= sumy[32] ? 32'hFFFFFFFF : sumy[31:0];
			mx_q <= nmx;
			my_q <= nmy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hit_latch) begin
			hit_side <= side_q;
			if (walk_out_q || sts.start_out) begin
				hit_x <= '0; hit_y <= '0; wall_code <= '0;
			end else begin
				hit_x <= 6'(mx_q[MW-1:0]);
				hit_y <= 6'(my_q[MW-1:0]);
				wall_code <= ram_rd;
			end
		end
	end
endmodule

>>> hdl/grdc_ctrl.sv
module grdc_ctrl import grdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      opcode,
	output logic      out_valid,
	input  logic      out_stall,
	output logic      out_escaped,
	output grdc_cmd_t cmd,
	output logic [1:0] div_phase,
	input  grdc_sts_t sts
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV0, S_DIVRUN, S_MUL1, S_MUL2, S_DIVREC,
		S_RECIP, S_INIT, S_INIT2, S_WALK, S_CHECK, S_DONE
	} state_t;
	state_t state_q;
	logic [1:0] ph_q;
	logic escaped_q, ov_q;
	assign div_phase = ph_q;
	assign out_valid = ov_q;
	assign out_escaped = escaped_q;

	// result slot is empty or being taken this cycle
	logic slot_free;
	assign slot_free = !ov_q || !out_stall;
	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.div_sel = ph_q != 2'd0;
		unique case (state_q)
			S_CLEAR:  cmd.clr_step = !sts.clr_done;
			S_IDLE: begin
				cmd.map_write = in_valid && !in_stall && opcode == OP_WRITE;
				cmd.load = in_valid && !in_stall && opcode == OP_CAST;
			end
			S_DIV0:   cmd.div_start = 1'b1;
			S_DIVRUN: cmd.div_step = 1'b1;
			S_MUL1, S_MUL2: cmd.mul_step = 1'b1;
			S_DIVREC: cmd.div_start = 1'b1;
			S_RECIP:  cmd.div_step = 1'b1;
			S_INIT:   cmd.side_init = 1'b1;
			S_WALK:   cmd.walk_step = 1'b1;
			S_CHECK:  cmd.hit_latch = sts.walk_out || sts.hit;
			S_DONE:   cmd.hit_latch = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ph_q <= '0;
			escaped_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (cmd.load) begin
					ph_q <= 2'd0;
					state_q <= S_DIV0;
				end
				S_DIV0: state_q <= S_DIVRUN;
				S_DIVRUN: if (sts.div_done) begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					ph_q <= ph_q + 1'b1;
					state_q <= (ph_q == 2'd1) ? S_MUL2 : S_MUL1;
				end
				S_MUL2: begin
					ph_q <= 2'd1;
					state_q <= S_DIVREC;
				end
				S_DIVREC: state_q <= S_RECIP;
				S_RECIP: if (sts.div_done) begin
					// recip latched this cycle
					if (ph_q == 2'd1) begin
						ph_q <= 2'd2;
						state_q <= S_DIVREC;
					end else state_q <= S_INIT;
				end
				S_INIT: state_q <= S_INIT2;
				S_INIT2: begin
					// hold until the previous result has been transferred
					if (slot_free) begin
						if (sts.start_out) begin
							escaped_q <= 1'b1;
							state_q <= S_DONE;
						end else state_q <= S_WALK;
					end
				end
				S_WALK: state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.walk_out || sts.hit) begin
						escaped_q <= sts.walk_out;
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else state_q <= S_WALK;
				end
				S_DONE: begin
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/grid_ray_dda_caster.sv
// Grid ray caster. Opcode 0 writes one map cell with no result; opcode 1
// casts a ray for a screen column and returns one result. A cast first runs
// setup after its transfer: a one-bit-per-cycle divider is run three times,
// for camera x, then the two reciprocal step distances. The walk then steps
// one grid cell at a time, each step going through a step state and a check
// state because of the map memory's registered read. The next item can be
// taken once the result is valid. A camera outside the map gives its escaped
// result without walking. A cast may be taken while the previous result still
// waits; its walk holds until that result has been transferred. After reset
// the map is cleared one cell per cycle (4096 cells by default, the cell
// count with MAP_SIZE rounded up to a power of two) before any item is taken.
module grid_ray_dda_caster import grdc_pkg::*; #(
	parameter int MAP_SIZE    = MAP_SIZE_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [5:0]            cell_x,
	input  logic [5:0]            cell_y,
	input  logic [7:0]            cell_code,
	input  logic [10:0]           column,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [5:0]            hit_x,
	output logic [5:0]            hit_y,
	output logic                  hit_side,
	output logic [7:0]            wall_code,
	output logic                  escaped
);
	logic [11:0] screen_width_q;
	logic [15:0] cam_pos_x_q, cam_pos_y_q;
	logic signed [15:0] view_dir_x_q, view_dir_y_q, cam_plane_x_q, cam_plane_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= 12'd640;
			cam_pos_x_q <= '0;
			cam_pos_y_q <= '0;
			view_dir_x_q <= -16'sd16384;
			view_dir_y_q <= '0;
			cam_plane_x_q <= '0;
			cam_plane_y_q <= 16'sd10813;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data[11:0];
				REG_CAM_POS_X:    cam_pos_x_q <= cfg_data;
				REG_CAM_POS_Y:    cam_pos_y_q <= cfg_data;
				REG_VIEW_DIR_X:   view_dir_x_q <= cfg_data;
				REG_VIEW_DIR_Y:   view_dir_y_q <= cfg_data;
				REG_CAM_PLANE_X:  cam_plane_x_q <= cfg_data;
				REG_CAM_PLANE_Y:  cam_plane_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	grdc_cmd_t  cmd;
	grdc_sts_t  sts;
	logic [1:0] div_phase;

	grdc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .out_valid(out_valid), .out_stall(out_stall),
		.out_escaped(escaped), .cmd(cmd), .div_phase(div_phase), .sts(sts)
	);

	grdc_datapath #(.MAP_SIZE(MAP_SIZE), .MAX_COLUMNS(MAX_COLUMNS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .div_phase(div_phase), .sts(sts),
		.screen_width(screen_width_q), .cam_pos_x(cam_pos_x_q),
		.cam_pos_y(cam_pos_y_q), .view_dir_x(view_dir_x_q),
		.view_dir_y(view_dir_y_q), .cam_plane_x(cam_plane_x_q),
		.cam_plane_y(cam_plane_y_q), .cell_x(cell_x), .cell_y(cell_y),
		.cell_code(cell_code), .column(column), .hit_x(hit_x), .hit_y(hit_y),
		.hit_side(hit_side), .wall_code(wall_code)
	);
endmodule
